@@ rtl/binary_insertion_sorter_top_defines.svh @@
// ----------------------------------------------------------------------------
// binary_insertion_sorter_top_defines.svh
// Assertion macros shared by the sorter's checker.
// ----------------------------------------------------------------------------
`ifndef BINARY_INSERTION_SORTER_TOP_DEFINES_SVH
`define BINARY_INSERTION_SORTER_TOP_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define BIS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define BIS_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/bis_pkg.sv @@
// ----------------------------------------------------------------------------
// bis_pkg
// Types and constants of the binary insertion sorter.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int unsigned IO_WIDTH = 32;

  typedef struct packed {
    logic signed [IO_WIDTH-1:0] value;
    logic                       last;
  } bis_in_t;

  typedef struct packed {
    logic signed [IO_WIDTH-1:0] sorted_value;
    logic                       final_res;
    logic                       overflowed;
  } bis_out_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } bis_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } bis_state_t;

endpackage

@@ rtl/bis_cell.sv @@
// ----------------------------------------------------------------------------
// bis_cell
// One slot of the sorting chain: holds one value and its occupied bit.
// ----------------------------------------------------------------------------
module bis_cell #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bis_pkg::bis_ctl_t     ctl,
  input  logic [DATA_WIDTH-1:0] new_value,
  input  logic                  prev_occ,
  input  logic                  prev_le,
  input  logic [DATA_WIDTH-1:0] prev_value,
  input  logic                  next_occ,
  input  logic [DATA_WIDTH-1:0] next_value,
  output logic                  occ,
  output logic                  le,
  output logic [DATA_WIDTH-1:0] value
);
  import bis_pkg::*;

  logic                  occ_next;
  logic [DATA_WIDTH-1:0] value_next;

  assign le = occ && ($signed(value) <= $signed(new_value));

  always_comb begin
    occ_next   = occ;
    value_next = value;
    if (ctl.shift) begin
      occ_next   = next_occ;
      value_next = next_value;
    end else if (ctl.insert) begin
      occ_next = occ | prev_occ;
      if (prev_occ && !prev_le) begin
        value_next = prev_value;
      end else if (prev_le && !le) begin
        value_next = new_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

@@ rtl/binary_insertion_sorter_top.sv @@
// ----------------------------------------------------------------------------
// binary_insertion_sorter_top
// Stable ascending sorter built from a chain of insertion cells.
// ----------------------------------------------------------------------------
// The item channel (item_valid, item_stall, item) takes one signed value per
// transfer. Every accepted value is compared against all cells at once and
// slots in after every stored value less than or equal to it, so one item is
// taken per cycle while loading. An item with last set is inserted as well
// and then starts the drain: the chain shifts toward cell zero one step per
// cycle and each value goes out on the result channel (res_valid, res_stall,
// res). Once the state register has entered the drain, the first result is
// registered in the output register. While draining, item_stall is high. A
// stall on the result side holds the output register and freezes the chain.
// The final value of a run carries final_res; overflowed is set on every
// result of a run in which values arrived while all MAX_ELEMS cells were full
// and were dropped. Reset empties the chain and clears the dropped flag.
// ----------------------------------------------------------------------------
module binary_insertion_sorter_top #(
  parameter int unsigned MAX_ELEMS  = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bis_pkg::bis_in_t  item,
  output logic              res_valid,
  input  logic              res_stall,
  output bis_pkg::bis_out_t res
);
  import bis_pkg::*;

  bis_state_t            state;
  bis_state_t            state_next;
  bis_ctl_t              ctl;
  logic                  accept;
  logic                  full;
  logic                  pop;
  logic                  pop_final;
  logic                  drop_flag;
  logic [DATA_WIDTH-1:0] new_value;
  logic [IO_WIDTH-1:0]   out_value;

  logic                  occ   [MAX_ELEMS];
  logic                  le    [MAX_ELEMS];
  logic [DATA_WIDTH-1:0] value [MAX_ELEMS];

  generate
    if (DATA_WIDTH == IO_WIDTH) begin : g_same
      assign new_value = item.value;
      assign out_value = value[0];
    end else if (DATA_WIDTH < IO_WIDTH) begin : g_narrow
      assign new_value = item.value[DATA_WIDTH-1:0];
      assign out_value = {{(IO_WIDTH - DATA_WIDTH){1'b0}}, value[0]};
    end else begin : g_wide
      assign new_value = {{(DATA_WIDTH - IO_WIDTH){1'b0}}, item.value};
      assign out_value = value[0][IO_WIDTH-1:0];
    end
  endgenerate

  assign full      = occ[MAX_ELEMS-1];
  assign accept    = item_valid && !item_stall;
  assign pop       = (state == ST_DRAIN) && (!res_valid || !res_stall);
  assign pop_final = pop && !occ[1];

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (accept && item.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pop_final) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    item_stall = 1'b0;
    ctl.insert = 1'b0;
    ctl.shift  = 1'b0;
    case (state)
      ST_LOAD: begin
        ctl.insert = accept && !full;
      end
      ST_DRAIN: begin
        item_stall = 1'b1;
        ctl.shift  = pop;
      end
      default: item_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      drop_flag <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && full) begin
        drop_flag <= 1'b1;
      end else if (pop_final) begin
        drop_flag <= 1'b0;
      end
      if (pop) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.sorted_value <= out_value;
      res.final_res    <= !occ[1];
      res.overflowed   <= drop_flag;
    end
  end

  generate
    for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
      logic                  p_occ;
      logic                  p_le;
      logic [DATA_WIDTH-1:0] p_value;
      logic                  n_occ;
      logic [DATA_WIDTH-1:0] n_value;

      if (i == 0) begin : g_head
        assign p_occ   = 1'b1;
        assign p_le    = 1'b1;
        assign p_value = new_value;
      end else begin : g_body
        assign p_occ   = occ[i-1];
        assign p_le    = le[i-1];
        assign p_value = value[i-1];
      end

      if (i == MAX_ELEMS - 1) begin : g_tail
        assign n_occ   = 1'b0;
        assign n_value = value[i];
      end else begin : g_link
        assign n_occ   = occ[i+1];
        assign n_value = value[i+1];
      end

      bis_cell #(
        .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .new_value (new_value),
        .prev_occ  (p_occ),
        .prev_le   (p_le),
        .prev_value(p_value),
        .next_occ  (n_occ),
        .next_value(n_value),
        .occ       (occ[i]),
        .le        (le[i]),
        .value     (value[i])
      );
    end
  endgenerate

endmodule

@@ rtl/bis_checker.sv @@
// ----------------------------------------------------------------------------
// bis_checker
// Port-level checks of the sorter, bound to its top level.
// ----------------------------------------------------------------------------
`include "binary_insertion_sorter_top_defines.svh"

module bis_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input bis_pkg::bis_in_t  item,
  input logic              res_valid,
  input logic              res_stall,
  input bis_pkg::bis_out_t res
);
  import bis_pkg::*;

  `BIS_ASSERT_NEXT(a_last_starts_drain, clk, rst, item_valid && !item_stall && item.last, item_stall, "Item channel not stalled after a last transfer.")

  `BIS_ASSERT_SAME(a_drain_holds_input, clk, rst, res_valid && !res.final_res, item_stall, "Item channel open while a run is still draining.")

  `BIS_ASSERT_NEXT(a_load_stays_open, clk, rst, item_valid && !item_stall && !item.last, !item_stall, "Item channel stalled after a transfer that was not last.")

  `BIS_ASSERT_NEXT(a_res_holds, clk, rst, res_valid && res_stall, res_valid && $stable(res), "Stalled result changed or dropped.")

endmodule

bind binary_insertion_sorter_top bis_checker u_bis_checker (
  .clk       (clk),
  .rst       (rst),
  .item_valid(item_valid),
  .item_stall(item_stall),
  .item      (item),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

@@ tb/sv/binary_insertion_sorter_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_insertion_sorter_top_test
// Self-checking bench for the stable ascending insertion sorter.
// ----------------------------------------------------------------------------
// A short table of directed items runs first: single-value sets at the
// extremes and around zero, a mixed set with duplicates and both extremes, a
// set of equal values and a two-value set. Random sets follow, including one
// that exactly fills the store and one that overflows it, so the last two
// values are dropped. Every accepted item goes through a behavioral sorter
// that queues the values the block must emit. Both channels idle at random,
// and the result side holds off once for a long stretch during a drain.
// ----------------------------------------------------------------------------
module binary_insertion_sorter_top_test;
  import bis_pkg::*;

  localparam int unsigned MAX_ELEMS    = 64;
  localparam int unsigned DATA_WIDTH   = 32;
  localparam int          TARGET_ITEMS = 320;
  localparam int          CALM_ITEMS   = 40;
  localparam int          HOLD_CYCLES  = 150;
  localparam int          TAIL_CYCLES  = 20;
  localparam int          LIMIT_CYCLES = 200000;

  localparam logic signed [IO_WIDTH-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [IO_WIDTH-1:0] MOST_POS = 32'sh7fff_ffff;

  typedef struct {
    logic signed [IO_WIDTH-1:0] value;
    logic                       last;
    bit                         typed;
    bis_out_t                   want;
  } stim_row_t;

  localparam int PLAN_ROWS = 17;

  stim_row_t plan [PLAN_ROWS] = '{
    '{MOST_NEG,      1'b1, 1'b1, '{MOST_NEG, 1'b1, 1'b0}},
    '{MOST_POS,      1'b1, 1'b1, '{MOST_POS, 1'b1, 1'b0}},
    '{32'sd0,        1'b1, 1'b1, '{32'sd0,   1'b1, 1'b0}},
    '{-32'sd1,       1'b1, 1'b1, '{-32'sd1,  1'b1, 1'b0}},
    '{32'sd5,        1'b0, 1'b0, '0},
    '{-32'sd3,       1'b0, 1'b0, '0},
    '{32'sd5,        1'b0, 1'b0, '0},
    '{MOST_POS,      1'b0, 1'b0, '0},
    '{MOST_NEG,      1'b0, 1'b0, '0},
    '{-32'sd1,       1'b0, 1'b0, '0},
    '{32'sd0,        1'b0, 1'b0, '0},
    '{32'sd5,        1'b1, 1'b0, '0},
    '{32'sd1,        1'b0, 1'b0, '0},
    '{32'sd1,        1'b0, 1'b0, '0},
    '{32'sd1,        1'b1, 1'b0, '0},
    '{32'sh5555_5555, 1'b0, 1'b0, '0},
    '{32'shAAAA_AAAA, 1'b1, 1'b0, '0}
  };

  logic     clk;
  logic     rst;
  logic     item_valid;
  logic     item_stall;
  bis_in_t  item;
  logic     res_valid;
  logic     res_stall;
  bis_out_t res;

  logic signed [DATA_WIDTH-1:0] sorted_held[$];
  bit                           run_dropped;
  bis_out_t                     awaited[$];
  int                           mismatches;
  int                           items_sent;
  int                           cycle_count;
  bit                           calm;
  bit                           hold_pending;

  binary_insertion_sorter_top #(
    .MAX_ELEMS (MAX_ELEMS),
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Places one value after every held value less than or equal to it (or marks
  // the set overflowed if full); the last item returns the whole set ascending.
  function automatic void sort_accept(input bis_in_t x, output bis_out_t produced[$]);
    logic signed [DATA_WIDTH-1:0] v;
    bis_out_t                     r;
    int                           pos;
    produced = {};
    v = x.value;
    if (sorted_held.size() < MAX_ELEMS) begin
      pos = 0;
      foreach (sorted_held[i]) if (sorted_held[i] <= v) pos++;
      sorted_held.insert(pos, v);
    end else begin
      run_dropped = 1'b1;
    end
    if (x.last) begin
      foreach (sorted_held[i]) begin
        r.sorted_value = sorted_held[i];
        r.final_res    = (i == sorted_held.size() - 1);
        r.overflowed   = run_dropped;
        produced.push_back(r);
      end
      sorted_held.delete();
      run_dropped = 1'b0;
    end
  endfunction

  function automatic logic signed [IO_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return MOST_NEG;
          1: return MOST_POS;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3: return $signed($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic offer_item(input bis_in_t x, input bit typed, input bis_out_t typed_res);
    bis_out_t produced[$];
    if (!calm && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item       <= x;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sort_accept(x, produced);
    if (typed) begin
      awaited.push_back(typed_res);
    end else begin
      foreach (produced[i]) awaited.push_back(produced[i]);
    end
    items_sent++;
  endtask

  initial begin
    bis_in_t x;
    int      run_len;
    int      run_idx;
    rst          <= 1'b1;
    item_valid   <= 1'b0;
    item         <= '0;
    run_dropped  = 1'b0;
    mismatches   = 0;
    items_sent   = 0;
    calm         = 1'b0;
    hold_pending = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      x.value = plan[i].value;
      x.last  = plan[i].last;
      offer_item(x, plan[i].typed, plan[i].want);
    end

    run_idx = 0;
    while (items_sent < TARGET_ITEMS) begin
      if (run_idx == 0) begin
        run_len = MAX_ELEMS;
      end else if (run_idx == 1) begin
        run_len = MAX_ELEMS + 2;
      end else if ($urandom_range(0, 9) == 0) begin
        run_len = $urandom_range(MAX_ELEMS - 8, MAX_ELEMS + 8);
      end else begin
        run_len = $urandom_range(1, 10);
      end
      for (int k = 0; k < run_len; k++) begin
        calm    = (items_sent >= TARGET_ITEMS - CALM_ITEMS);
        x.value = pick_value();
        x.last  = (k == run_len - 1);
        offer_item(x, 1'b0, '0);
      end
      if (run_idx == 0) hold_pending = 1'b1;
      run_idx++;
    end
    item_valid <= 1'b0;

    while (awaited.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    res_stall <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (calm || $urandom_range(0, 2) != 0) begin
        res_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    bis_out_t want;
    if (!rst && res_valid && !res_stall) begin
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %0d", $time,
                 res.sorted_value);
        mismatches++;
      end else begin
        want = awaited.pop_front();
        if (res.sorted_value !== want.sorted_value) begin
          $display("%0t: sorted_value mismatch: expected %0d, actual %0d", $time,
                   want.sorted_value, res.sorted_value);
          mismatches++;
        end
        if (res.final_res !== want.final_res) begin
          $display("%0t: final_res mismatch: expected %b, actual %b", $time,
                   want.final_res, res.final_res);
          mismatches++;
        end
        if (res.overflowed !== want.overflowed) begin
          $display("%0t: overflowed mismatch: expected %b, actual %b", $time,
                   want.overflowed, res.overflowed);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule
